// ===== design/bpc_pkg.sv =====
// Package for the barometric pressure compensation block.
// Holds widths, shift amounts, register indexes and the structs between stages.
// No dependencies.
package bpc_pkg;

    localparam int RAW_W     = 24;
    localparam int COEFF_W   = 16;
    localparam int TEMP_W    = 19;
    localparam int PRES_W    = 32;
    localparam int REG_IDX_W = 3;

    localparam int DT_W    = RAW_W + 1;
    localparam int MUL_W   = DT_W + COEFF_W + 1;
    localparam int DD_W    = 2 * DT_W;
    localparam int T2_W    = 17;
    localparam int OFF_W   = 35;
    localparam int SENS_W  = 34;
    localparam int SQ_W    = 35;
    localparam int CORR2_W = 38;
    localparam int CORR_W  = 40;
    localparam int LO_W    = 20;
    localparam int HI_W    = CORR_W - LO_W;
    localparam int PPL_W   = RAW_W + LO_W;
    localparam int PPH_W   = RAW_W + 1 + HI_W;
    localparam int PROD_W  = 64;
    localparam int PD_W    = 44;
    localparam int Q_W     = 45;

    localparam int SH_REF  = 8;
    localparam int SH_T    = 23;
    localparam int SH_OFF  = 7;
    localparam int SH_SENS = 8;
    localparam int SH_T2   = 31;
    localparam int SH_C2   = 16;
    localparam int SH_C1   = 15;
    localparam int SH_P1   = 21;
    localparam int SH_P2   = 15;

    localparam logic signed [TEMP_W-1:0] TEMP_REF = 19'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_LOW = -19'sd1500;

    localparam logic [REG_IDX_W-1:0] REG_SENS      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SENS_TEMP = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OFF_TEMP  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_REF_TEMP  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SLOPE     = 3'd5;

    typedef struct packed {
        logic [COEFF_W-1:0] c1;
        logic [COEFF_W-1:0] c2;
        logic [COEFF_W-1:0] c3;
        logic [COEFF_W-1:0] c4;
        logic [COEFF_W-1:0] c5;
        logic [COEFF_W-1:0] c6;
    } t_coeffs;

    typedef struct packed {
        logic        [RAW_W-1:0]  d1;
        logic signed [TEMP_W-1:0] temp;
        logic        [T2_W-1:0]   t2;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
    } t_first;

    typedef struct packed {
        logic        [RAW_W-1:0]  d1;
        logic signed [TEMP_W-1:0] temp;
        logic signed [CORR_W-1:0] off_c;
        logic signed [CORR_W-1:0] sens_c;
    } t_second;

endpackage

// ===== design/bpc_in_if.sv =====
// Input channel: one raw pressure and temperature conversion pair per transaction.
// Depends on bpc_pkg for field widths.
interface bpc_in_if;
    logic                       valid;
    logic                       ready;
    logic [bpc_pkg::RAW_W-1:0]  raw_pressure;
    logic [bpc_pkg::RAW_W-1:0]  raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

// ===== design/bpc_out_if.sv =====
// Output channel: compensated temperature and pressure per transaction.
// Depends on bpc_pkg for field widths.
interface bpc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [bpc_pkg::TEMP_W-1:0]   temperature;
    logic signed [bpc_pkg::PRES_W-1:0]   pressure;

    modport source (output valid, output temperature, output pressure, input ready);
    modport sink   (input valid, input temperature, input pressure, output ready);
endinterface

// ===== design/bpc_first.sv =====
// First-order compensation: dT, the three coefficient products and dT squared.
// Three register stages. Depends on bpc_pkg.
module bpc_first (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  bpc_pkg::t_coeffs        i_coeffs,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [bpc_pkg::RAW_W-1:0] i_d1,
    input  logic [bpc_pkg::RAW_W-1:0] i_d2,
    output logic                    o_valid,
    input  logic                    i_ready,
    output bpc_pkg::t_first         o_data
);
    import bpc_pkg::*;

    logic r_v1, r_v2, r_v3;
    logic w_en1, w_en2, w_en3;

    logic        [RAW_W-1:0] r1_d1;
    logic signed [DT_W-1:0]  r1_dt;
    logic signed [DT_W-1:0]  n_dt;

    logic        [RAW_W-1:0] r2_d1;
    logic signed [MUL_W-1:0] r2_p6, r2_p4, r2_p3;
    logic signed [DD_W-1:0]  r2_dd;

    logic signed [MUL_W-1:0] n_bias6, n_bias4, n_bias3;
    logic signed [MUL_W-1:0] n_p6_adj, n_p4_adj, n_p3_adj;
    t_first                  n_first;
    t_first                  r3_data;

    assign w_en3   = !r_v3 || i_ready;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r_v3;
    assign o_data  = r3_data;

    assign n_dt = $signed({1'b0, i_d2}) - $signed({1'b0, i_coeffs.c5, {SH_REF{1'b0}}});

    assign n_bias6 = r2_p6[MUL_W-1] ? MUL_W'((64'd1 << SH_T) - 64'd1) : '0;
    assign n_bias4 = r2_p4[MUL_W-1] ? MUL_W'((64'd1 << SH_OFF) - 64'd1) : '0;
    assign n_bias3 = r2_p3[MUL_W-1] ? MUL_W'((64'd1 << SH_SENS) - 64'd1) : '0;
    assign n_p6_adj = r2_p6 + n_bias6;
    assign n_p4_adj = r2_p4 + n_bias4;
    assign n_p3_adj = r2_p3 + n_bias3;

    always_comb begin
        n_first.d1   = r2_d1;
        n_first.temp = TEMP_W'(n_p6_adj >>> SH_T) + TEMP_REF;
        n_first.t2   = T2_W'(r2_dd >> SH_T2);
        n_first.off  = OFF_W'($signed({1'b0, i_coeffs.c2, {SH_C2{1'b0}}}))
                     + OFF_W'(n_p4_adj >>> SH_OFF);
        n_first.sens = SENS_W'($signed({1'b0, i_coeffs.c1, {SH_C1{1'b0}}}))
                     + SENS_W'(n_p3_adj >>> SH_SENS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_d1 <= i_d1;
            r1_dt <= n_dt;
        end
        if (w_en2) begin
            r2_d1 <= r1_d1;
            r2_p6 <= r1_dt * $signed({1'b0, i_coeffs.c6});
            r2_p4 <= r1_dt * $signed({1'b0, i_coeffs.c4});
            r2_p3 <= r1_dt * $signed({1'b0, i_coeffs.c3});
            r2_dd <= r1_dt * r1_dt;
        end
        if (w_en3) begin
            r3_data <= n_first;
        end
    end

endmodule

// ===== design/bpc_second.sv =====
// Second-order correction below the reference and low temperatures.
// Three register stages: squares, correction terms, corrected offset and sensitivity.
// Depends on bpc_pkg.
module bpc_second (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  bpc_pkg::t_first  i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output bpc_pkg::t_second o_data
);
    import bpc_pkg::*;

    logic r_v4, r_v5, r_v6;
    logic w_en4, w_en5, w_en6;

    logic signed [TEMP_W:0]     n_a, n_b;
    logic signed [2*TEMP_W+1:0] n_a2, n_b2;

    t_first              r4_data;
    logic [SQ_W-1:0]     r4_a2, r4_b2;
    logic                r4_lt_ref, r4_lt_low;

    logic [CORR2_W-1:0]  n_a5, n_b7, n_b11, n_off2, n_sens2;
    logic signed [TEMP_W-1:0] n_temp;

    logic        [RAW_W-1:0]   r5_d1;
    logic signed [TEMP_W-1:0]  r5_temp;
    logic signed [OFF_W-1:0]   r5_off;
    logic signed [SENS_W-1:0]  r5_sens;
    logic        [CORR2_W-1:0] r5_off2, r5_sens2;

    t_second n_second;
    t_second r6_data;

    assign w_en6   = !r_v6 || i_ready;
    assign w_en5   = !r_v5 || w_en6;
    assign w_en4   = !r_v4 || w_en5;
    assign o_ready = w_en4;
    assign o_valid = r_v6;
    assign o_data  = r6_data;

    assign n_a  = (TEMP_W+1)'(i_data.temp) - (TEMP_W+1)'(TEMP_REF);
    assign n_b  = (TEMP_W+1)'(i_data.temp) - (TEMP_W+1)'(TEMP_LOW);
    assign n_a2 = n_a * n_a;
    assign n_b2 = n_b * n_b;

    assign n_a5  = (CORR2_W'(r4_a2) << 2) + CORR2_W'(r4_a2);
    assign n_b7  = (CORR2_W'(r4_b2) << 3) - CORR2_W'(r4_b2);
    assign n_b11 = (CORR2_W'(r4_b2) << 3) + (CORR2_W'(r4_b2) << 1) + CORR2_W'(r4_b2);

    assign n_off2  = (r4_lt_ref ? (n_a5 >> 1) : '0) + (r4_lt_low ? n_b7 : '0);
    assign n_sens2 = (r4_lt_ref ? (n_a5 >> 2) : '0) + (r4_lt_low ? (n_b11 >> 1) : '0);
    assign n_temp  = r4_data.temp
                   - (r4_lt_ref ? TEMP_W'($signed({1'b0, r4_data.t2})) : '0);

    always_comb begin
        n_second.d1     = r5_d1;
        n_second.temp   = r5_temp;
        n_second.off_c  = CORR_W'(r5_off) - CORR_W'($signed({1'b0, r5_off2}));
        n_second.sens_c = CORR_W'(r5_sens) - CORR_W'($signed({1'b0, r5_sens2}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (w_en4) r_v4 <= i_valid;
            if (w_en5) r_v5 <= r_v4;
            if (w_en6) r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r4_data   <= i_data;
            r4_a2     <= SQ_W'(n_a2);
            r4_b2     <= SQ_W'(n_b2);
            r4_lt_ref <= i_data.temp < TEMP_REF;
            r4_lt_low <= i_data.temp < TEMP_LOW;
        end
        if (w_en5) begin
            r5_d1    <= r4_data.d1;
            r5_temp  <= n_temp;
            r5_off   <= r4_data.off;
            r5_sens  <= r4_data.sens;
            r5_off2  <= n_off2;
            r5_sens2 <= n_sens2;
        end
        if (w_en6) begin
            r6_data <= n_second;
        end
    end

endmodule

// ===== design/bpc_press.sv =====
// Pressure formation: split product of raw pressure and sensitivity, scaling, offset.
// Five register stages, the last one is the output register. Depends on bpc_pkg.
module bpc_press (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  bpc_pkg::t_second                 i_data,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [bpc_pkg::TEMP_W-1:0] o_temperature,
    output logic signed [bpc_pkg::PRES_W-1:0] o_pressure
);
    import bpc_pkg::*;

    logic r_v7, r_v8, r_v9, r_v10, r_v11;
    logic w_en7, w_en8, w_en9, w_en10, w_en11;

    logic signed [TEMP_W-1:0] r7_temp, r8_temp, r9_temp, r10_temp, r11_temp;
    logic signed [CORR_W-1:0] r7_off, r8_off, r9_off;

    logic        [PPL_W-1:0]  r7_pp_lo;
    logic signed [PPH_W-1:0]  r7_pp_hi;
    logic signed [PROD_W-1:0] r8_prod;
    logic signed [PROD_W-1:0] n_prod, n_bias1, n_prod_adj;
    logic signed [PD_W-1:0]   r9_pd;
    logic signed [Q_W-1:0]    r10_q;
    logic signed [Q_W-1:0]    n_bias2, n_q_adj;
    logic signed [PRES_W-1:0] r11_p;

    assign w_en11  = !r_v11 || i_ready;
    assign w_en10  = !r_v10 || w_en11;
    assign w_en9   = !r_v9  || w_en10;
    assign w_en8   = !r_v8  || w_en9;
    assign w_en7   = !r_v7  || w_en8;
    assign o_ready = w_en7;

    assign o_valid       = r_v11;
    assign o_temperature = r11_temp;
    assign o_pressure    = r11_p;

    assign n_prod     = (PROD_W'(r7_pp_hi) <<< LO_W) + PROD_W'($signed({1'b0, r7_pp_lo}));
    assign n_bias1    = r8_prod[PROD_W-1] ? PROD_W'((64'd1 << SH_P1) - 64'd1) : '0;
    assign n_prod_adj = r8_prod + n_bias1;
    assign n_bias2    = r10_q[Q_W-1] ? Q_W'((64'd1 << SH_P2) - 64'd1) : '0;
    assign n_q_adj    = r10_q + n_bias2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7  <= 1'b0;
            r_v8  <= 1'b0;
            r_v9  <= 1'b0;
            r_v10 <= 1'b0;
            r_v11 <= 1'b0;
        end else begin
            if (w_en7)  r_v7  <= i_valid;
            if (w_en8)  r_v8  <= r_v7;
            if (w_en9)  r_v9  <= r_v8;
            if (w_en10) r_v10 <= r_v9;
            if (w_en11) r_v11 <= r_v10;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en7) begin
            r7_temp  <= i_data.temp;
            r7_off   <= i_data.off_c;
            r7_pp_lo <= i_data.d1 * i_data.sens_c[LO_W-1:0];
            r7_pp_hi <= $signed({1'b0, i_data.d1}) * $signed(i_data.sens_c[CORR_W-1:LO_W]);
        end
        if (w_en8) begin
            r8_temp <= r7_temp;
            r8_off  <= r7_off;
            r8_prod <= n_prod;
        end
        if (w_en9) begin
            r9_temp <= r8_temp;
            r9_off  <= r8_off;
            r9_pd   <= PD_W'(n_prod_adj >>> SH_P1);
        end
        if (w_en10) begin
            r10_temp <= r9_temp;
            r10_q    <= Q_W'(r9_pd) - Q_W'(r9_off);
        end
        if (w_en11) begin
            r11_temp <= r10_temp;
            r11_p    <= PRES_W'(n_q_adj >>> SH_P2);
        end
    end

endmodule

// ===== design/baro_pressure_compensation_top.sv =====
// Top level of the barometric pressure compensation block: calibration registers
// and the three pipeline sections. Depends on bpc_pkg, bpc_in_if, bpc_out_if,
// bpc_first, bpc_second and bpc_press.
//
//  channel  direction  transaction           fields
//  i_in     in         valid && ready        raw_pressure, raw_temperature
//  o_out    out        valid && ready        temperature, pressure
//  i_cfg    in         i_cfg_we (no wait)    i_cfg_idx, i_cfg_data
//
// One transaction per cycle sustained while o_out.ready stays high; each result
// passes through the eleven register stages of the datapath.
// Synchronous active-low reset clears the stage valid bits and the coefficients.
// On a stall the stages hold; empty stages keep filling, and i_in.ready falls
// only once every stage holds an item.
module baro_pressure_compensation_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bpc_pkg::REG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bpc_pkg::COEFF_W-1:0]         i_cfg_data,
    bpc_in_if.sink                              i_in,
    bpc_out_if.source                           o_out
);
    import bpc_pkg::*;

    t_coeffs r_coeffs;

    logic    w_fs_valid, w_fs_ready;
    t_first  w_fs_data;
    logic    w_sp_valid, w_sp_ready;
    t_second w_sp_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeffs <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SENS:      r_coeffs.c1 <= i_cfg_data;
                REG_OFFSET:    r_coeffs.c2 <= i_cfg_data;
                REG_SENS_TEMP: r_coeffs.c3 <= i_cfg_data;
                REG_OFF_TEMP:  r_coeffs.c4 <= i_cfg_data;
                REG_REF_TEMP:  r_coeffs.c5 <= i_cfg_data;
                REG_SLOPE:     r_coeffs.c6 <= i_cfg_data;
                default:       r_coeffs    <= r_coeffs;
            endcase
        end
    end

    bpc_first u_first (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_coeffs (r_coeffs),
        .i_valid  (i_in.valid),
        .o_ready  (i_in.ready),
        .i_d1     (i_in.raw_pressure),
        .i_d2     (i_in.raw_temperature),
        .o_valid  (w_fs_valid),
        .i_ready  (w_fs_ready),
        .o_data   (w_fs_data)
    );

    bpc_second u_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fs_valid),
        .o_ready (w_fs_ready),
        .i_data  (w_fs_data),
        .o_valid (w_sp_valid),
        .i_ready (w_sp_ready),
        .o_data  (w_sp_data)
    );

    bpc_press u_press (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_sp_valid),
        .o_ready       (w_sp_ready),
        .i_data        (w_sp_data),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready),
        .o_temperature (o_out.temperature),
        .o_pressure    (o_out.pressure)
    );

`ifndef SYNTHESIS
    a_in_stall_needs_full_out: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready && w_sp_valid && w_fs_valid)
    ) else $error("input stalled while the pipeline has a free stage");

    a_first_stall_chain: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_fs_valid && !w_fs_ready) |-> (w_sp_valid && !w_sp_ready)
    ) else $error("first section stalled without a stall further on");

    a_press_stall_chain: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_sp_valid && !w_sp_ready) |-> (o_out.valid && !o_out.ready)
    ) else $error("pressure section stalled without an output stall");

    a_out_after_reset: assert property (
        @(posedge i_clk)
        !i_rst_n |=> !o_out.valid
    ) else $error("result shown straight after reset");
`endif

endmodule

// ===== dv/tb_baro_pressure_compensation_top.sv =====
// Testbench for baro_pressure_compensation_top: drives raw conversion pairs and
// calibration words, predicts each compensated reading and checks it in order.
// Depends on bpc_pkg, bpc_in_if, bpc_out_if and the design sources.
module tb_baro_pressure_compensation_top;
    import bpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int SETTLE_CYCLES  = 30;

    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [RAW_W-1:0]   RAW_MAX = '1;
    localparam logic [COEFF_W-1:0] CAL_MAX = '1;

    localparam longint TEMP_WARM = 2000;
    localparam longint TEMP_COLD = -1500;
    localparam longint POW2_7    = 64'sd128;
    localparam longint POW2_8    = 64'sd256;
    localparam longint POW2_15   = 64'sd32768;
    localparam longint POW2_16   = 64'sd65536;
    localparam longint POW2_21   = 64'sd2097152;
    localparam longint POW2_23   = 64'sd8388608;
    localparam longint POW2_31   = 64'sd2147483648;

    localparam t_coeffs CAL_TYPICAL = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317,
                                        c4: 16'd23282, c5: 16'd33464, c6: 16'd28312};

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic signed [PRES_W-1:0] pressure;
    } t_reading;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [REG_IDX_W-1:0] i_cfg_idx;
    logic [COEFF_W-1:0]   i_cfg_data;

    bpc_in_if  in_ch();
    bpc_out_if out_ch();

    t_coeffs  cal_words;
    t_reading expected_readings[$];
    int       error_count;
    int       idle_cycles;
    bit       full_rate;

    baro_pressure_compensation_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic t_reading compensate(t_coeffs c, logic [RAW_W-1:0] d1,
                                            logic [RAW_W-1:0] d2);
        longint k1, k2, k3, k4, k5, k6;
        longint p_raw, t_raw, dt, temp, off, sens;
        longint t2, off2, sens2, a, b, p;
        t_reading r;
        k1 = c.c1;
        k2 = c.c2;
        k3 = c.c3;
        k4 = c.c4;
        k5 = c.c5;
        k6 = c.c6;
        p_raw = d1;
        t_raw = d2;
        dt   = t_raw - k5 * POW2_8;
        temp = TEMP_WARM + (dt * k6) / POW2_23;
        off  = k2 * POW2_16 + (dt * k4) / POW2_7;
        sens = k1 * POW2_15 + (dt * k3) / POW2_8;
        t2    = 0;
        off2  = 0;
        sens2 = 0;
        if (temp < TEMP_WARM) begin
            a     = temp - TEMP_WARM;
            t2    = (dt * dt) / POW2_31;
            off2  = (5 * a * a) / 2;
            sens2 = (5 * a * a) / 4;
        end
        if (temp < TEMP_COLD) begin
            b     = temp - TEMP_COLD;
            off2  = off2 + 7 * b * b;
            sens2 = sens2 + (11 * b * b) / 2;
        end
        temp = temp - t2;
        off  = off - off2;
        sens = sens - sens2;
        p = ((p_raw * sens) / POW2_21 - off) / POW2_15;
        r.temperature = TEMP_W'(temp);
        r.pressure    = PRES_W'(p);
        return r;
    endfunction

    // Predict on each input transaction, check on each output transaction.
    always @(posedge i_clk) begin
        t_reading want;
        bit       moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (in_ch.valid && in_ch.ready) begin
                expected_readings.push_back(compensate(cal_words, in_ch.raw_pressure,
                                                       in_ch.raw_temperature));
                moved = 1'b1;
            end
            if (out_ch.valid && out_ch.ready) begin
                moved = 1'b1;
                if (expected_readings.size() == 0) begin
                    if (error_count < MAX_REPORTS) begin
                        $display("unexpected reading: temperature %0d pressure %0d",
                                 out_ch.temperature, out_ch.pressure);
                    end
                    error_count++;
                end else begin
                    want = expected_readings.pop_front();
                    if (want.temperature !== out_ch.temperature ||
                        want.pressure !== out_ch.pressure) begin
                        if (error_count < MAX_REPORTS) begin
                            $display({"mismatch: temperature exp %0d got %0d, ",
                                      "pressure exp %0d got %0d"},
                                     want.temperature, out_ch.temperature,
                                     want.pressure, out_ch.pressure);
                        end
                        error_count++;
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_baro_pressure_compensation_top: FAIL");
                $finish;
            end
        end
    end

    initial begin
        int burst;
        int stall;
        burst = 0;
        stall = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (full_rate) begin
                out_ch.ready <= 1'b1;
            end else if (burst > 0) begin
                out_ch.ready <= 1'b1;
                burst--;
            end else if (stall > 0) begin
                out_ch.ready <= 1'b0;
                stall--;
            end else begin
                burst = $urandom_range(1, 40) - 1;
                stall = pick_gap();
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_conversion(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t);
        int gap;
        gap = full_rate ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid           <= 1'b1;
        in_ch.raw_pressure    <= p;
        in_ch.raw_temperature <= t;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_random_conversion();
        logic [RAW_W-1:0] p;
        logic [RAW_W-1:0] t;
        longint centre;
        longint spread;
        longint offset;
        longint target;
        p = RAW_W'($urandom());
        if ($urandom_range(0, 99) < 60) begin
            // aim close to the reference temperature so every band is reached
            spread = (longint'(1) << $urandom_range(0, RAW_W)) - 1;
            centre = longint'(cal_words.c5) * POW2_8;
            offset = longint'($urandom()) & spread;
            target = $urandom_range(0, 1) ? centre - offset : centre + offset;
            if (target < 0) begin
                target = 0;
            end else if (target > longint'(RAW_MAX)) begin
                target = RAW_MAX;
            end
            t = RAW_W'(target);
        end else begin
            t = RAW_W'($urandom());
        end
        send_conversion(p, t);
    endtask

    task automatic drain_readings();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_cal_word(input logic [REG_IDX_W-1:0] idx,
                                  input logic [COEFF_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_SENS:      cal_words.c1 = data;
            REG_OFFSET:    cal_words.c2 = data;
            REG_SENS_TEMP: cal_words.c3 = data;
            REG_OFF_TEMP:  cal_words.c4 = data;
            REG_REF_TEMP:  cal_words.c5 = data;
            REG_SLOPE:     cal_words.c6 = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_cal(input t_coeffs c);
        write_cal_word(REG_SENS, c.c1);
        write_cal_word(REG_OFFSET, c.c2);
        write_cal_word(REG_SENS_TEMP, c.c3);
        write_cal_word(REG_OFF_TEMP, c.c4);
        write_cal_word(REG_REF_TEMP, c.c5);
        write_cal_word(REG_SLOPE, c.c6);
    endtask

    function automatic logic [COEFF_W-1:0] pick_cal_word(int flavour,
                                                        logic [COEFF_W-1:0] typical);
        int r;
        if (flavour == 0) begin
            return COEFF_W'($urandom());
        end else if (flavour == 1) begin
            return typical + COEFF_W'($urandom_range(0, 8191)) - COEFF_W'(4096);
        end
        r = $urandom_range(0, 2);
        return (r == 0) ? '0 : (r == 1) ? CAL_MAX : COEFF_W'($urandom());
    endfunction

    task automatic load_random_cal(input int flavour);
        t_coeffs c;
        c.c1 = pick_cal_word(flavour, CAL_TYPICAL.c1);
        c.c2 = pick_cal_word(flavour, CAL_TYPICAL.c2);
        c.c3 = pick_cal_word(flavour, CAL_TYPICAL.c3);
        c.c4 = pick_cal_word(flavour, CAL_TYPICAL.c4);
        c.c5 = pick_cal_word(flavour, CAL_TYPICAL.c5);
        c.c6 = pick_cal_word(flavour, CAL_TYPICAL.c6);
        load_cal(c);
    endtask

    task automatic test_reset_state();
        send_conversion('0, '0);
        send_conversion(RAW_MAX, RAW_MAX);
        send_conversion(RAW_MAX, '0);
        send_conversion('0, RAW_MAX);
        drain_readings();
    endtask

    // slope of 2^13 gives one hundredth of a degree per 1024 counts
    task automatic test_temperature_bands();
        t_coeffs c;
        logic [RAW_W-1:0] ref_t;
        c    = CAL_TYPICAL;
        c.c6 = 16'd8192;
        load_cal(c);
        ref_t = RAW_W'(longint'(c.c5) * POW2_8);
        send_conversion(24'd9085466, ref_t);
        send_conversion(24'd9085466, ref_t + 24'd5000);
        send_conversion(24'd9085466, ref_t - 24'd1023);
        send_conversion(24'd9085466, ref_t - 24'd1024);
        send_conversion(24'd9085466, ref_t - 24'd2000000);
        send_conversion(24'd9085466, ref_t - 24'd3584000);
        send_conversion(24'd9085466, ref_t - 24'd3585024);
        send_conversion(RAW_MAX, '0);
        send_conversion('0, RAW_MAX);
        send_conversion(RAW_MAX, RAW_MAX);
        drain_readings();
    endtask

    task automatic test_spare_indexes();
        write_cal_word(REG_SPARE_LO, 16'hA5A5);
        write_cal_word(REG_SPARE_HI, CAL_MAX);
        send_conversion(24'd9085466, RAW_W'(longint'(cal_words.c5) * POW2_8));
        send_conversion(RAW_MAX, 24'd1000000);
        send_conversion(24'd1, RAW_MAX);
        drain_readings();
    endtask

    task automatic test_cal_extremes();
        t_coeffs c;
        c = '{c1: CAL_MAX, c2: CAL_MAX, c3: CAL_MAX, c4: CAL_MAX, c5: CAL_MAX, c6: CAL_MAX};
        load_cal(c);
        repeat (50) send_random_conversion();
        drain_readings();
        c = '{c1: '0, c2: '0, c3: '0, c4: '0, c5: CAL_MAX, c6: CAL_MAX};
        load_cal(c);
        repeat (50) send_random_conversion();
        drain_readings();
        c = '{c1: CAL_MAX, c2: '0, c3: CAL_MAX, c4: '0, c5: CAL_MAX, c6: '0};
        load_cal(c);
        repeat (50) send_random_conversion();
        drain_readings();
    endtask

    // hold the sender midway until every reading is back
    task automatic test_random_cal();
        for (int phase = 0; phase < 5; phase++) begin
            load_random_cal(phase % 3);
            repeat (60) send_random_conversion();
            drain_readings();
            repeat (60) send_random_conversion();
            drain_readings();
        end
    endtask

    task automatic test_full_rate();
        load_cal(CAL_TYPICAL);
        full_rate = 1'b1;
        repeat (100) send_random_conversion();
        drain_readings();
        full_rate = 1'b0;
    endtask

    initial begin
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = '0;
        i_cfg_data            = '0;
        in_ch.valid           = 1'b0;
        in_ch.raw_pressure    = '0;
        in_ch.raw_temperature = '0;
        cal_words             = '0;
        error_count           = 0;
        idle_cycles           = 0;
        full_rate             = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_temperature_bands();
        test_spare_indexes();
        test_cal_extremes();
        test_random_cal();
        test_full_rate();

        drain_readings();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_readings.size() == 0) begin
            $display("tb_baro_pressure_compensation_top: PASS");
        end else begin
            $display("tb_baro_pressure_compensation_top: FAIL");
        end
        $finish;
    end
endmodule
